[design/spms_pkg.sv]
// Shared types and constants for the step/pause/move sequencer.
`default_nettype none
package spms_pkg;

    localparam int unsigned ADC_W       = 10;
    localparam int unsigned STEPS_W     = 21;
    localparam int unsigned DIST_W      = 22;
    localparam int unsigned TICKS_W     = 32;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned COOL_W      = 8;
    localparam int unsigned DISP_W      = 3;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned S_DATA_W    = 16;
    localparam int unsigned M_DATA_W    = 48;

    localparam logic [COOL_W-1:0] COOLDOWN_RELOAD = 8'd250;

    // keypad ladder: below 539 is a direction key, 539..796 is SELECT, above is no key
    localparam logic [ADC_W-1:0] KEY_SELECT_LO = 10'd539;
    localparam logic [ADC_W-1:0] KEY_SELECT_HI = 10'd796;

    // ceil(2^26 / 5): steps = (|um| * 4) / 5, exact for operands below 2^26
    localparam int unsigned       DIV5_SHIFT = 26;
    localparam logic [23:0]       DIV5_MUL   = 24'd13421773;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DIST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_COUNT  = 2'd2;

    localparam logic [STEPS_W-1:0] RST_STEPS       = 21'd1600;
    localparam logic [TICKS_W-1:0] RST_PAUSE_TICKS = 32'd1000;
    localparam logic [COUNT_W-1:0] RST_MOVE_COUNT  = 16'd3;

    localparam logic [DISP_W-1:0] DISP_NONE     = 3'd0;
    localparam logic [DISP_W-1:0] DISP_RUNNING  = 3'd1;
    localparam logic [DISP_W-1:0] DISP_PAUSED   = 3'd2;
    localparam logic [DISP_W-1:0] DISP_ABORTED  = 3'd3;
    localparam logic [DISP_W-1:0] DISP_FINISHED = 3'd4;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [1:0] {
        KEY_NONE   = 2'd0,
        KEY_SELECT = 2'd1,
        KEY_OTHER  = 2'd2
    } t_key;

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_MOVE  = 5'b00010,
        PH_WAIT  = 5'b00100,
        PH_PAUSE = 5'b01000,
        PH_EXIT  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic command;
        t_key key;
        logic motion_busy;
    } t_item;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic               active;
        logic [COUNT_W-1:0] steps_left;
        logic [DISP_W-1:0]  display_code;
        logic               move_reverse;
        logic [STEPS_W-1:0] move_steps;
        logic               move_request;
        logic               exited;
    } t_result;

endpackage
`default_nettype wire

[design/spms_front.sv]
// Front part: unpacks incoming transfers and classifies the keypad sample.
`default_nettype none
module spms_front (
    input  wire logic                          i_tuser,
    input  wire logic [spms_pkg::S_DATA_W-1:0] i_tdata,
    output spms_pkg::t_item                    o_item
);
    import spms_pkg::*;

    logic [ADC_W-1:0] w_sample;
    t_key             w_key;

    assign w_sample = i_tdata[ADC_W-1:0];

    always_comb begin
        if (w_sample inside {[KEY_SELECT_LO:KEY_SELECT_HI]}) begin
            w_key = KEY_SELECT;
        end else if (w_sample < KEY_SELECT_LO) begin
            w_key = KEY_OTHER;
        end else begin
            w_key = KEY_NONE;
        end
    end

    always_comb begin
        o_item.command     = i_tuser;
        o_item.key         = w_key;
        o_item.motion_busy = i_tdata[ADC_W];
    end

endmodule
`default_nettype wire

[design/spms_queue.sv]
// Two-entry queue between the classifier and the sequencer.
`default_nettype none
module spms_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire spms_pkg::t_item i_item,
    output logic           o_full,
    input  wire logic      i_pop,
    output logic           o_valid,
    output spms_pkg::t_item o_item
);
    import spms_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

[design/spms_back.sv]
// Back part: run state, config registers and the registered result stage.
`default_nettype none
module spms_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire spms_pkg::t_cfg_wr i_cfg,
    input  wire logic            i_valid,
    input  wire spms_pkg::t_item i_item,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output spms_pkg::t_result    o_result
);
    import spms_pkg::*;

    // config: the step magnitude is converted when the register is written
    logic [STEPS_W-1:0] r_cfg_steps;
    logic               r_cfg_rev;
    logic [TICKS_W-1:0] r_pause_ticks;
    logic [COUNT_W-1:0] r_move_count;

    logic               r_running, n_running;
    t_phase             r_phase, n_phase;
    logic               r_paused, n_paused;
    logic [COOL_W-1:0]  r_cooldown, n_cooldown;
    logic [COUNT_W-1:0] r_moves_left, n_moves_left;
    logic [TICKS_W-1:0] r_pause_rem, n_pause_rem;

    logic               r_out_valid;
    t_result            r_out, n_out;

    logic [DIST_W-1:0]  w_dist;
    logic [DIST_W-1:0]  w_mag;
    logic [23:0]        w_mag4;
    logic [47:0]        w_prod;
    logic [COUNT_W-1:0] w_dec;
    t_key               w_key;
    logic               w_done;

    assign w_dist = i_cfg.data[DIST_W-1:0];
    assign w_mag  = w_dist[DIST_W-1] ? (~w_dist + 22'd1) : w_dist;
    assign w_mag4 = {w_mag, 2'b00};
    assign w_prod = w_mag4 * DIV5_MUL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_steps   <= RST_STEPS;
            r_cfg_rev     <= 1'b0;
            r_pause_ticks <= RST_PAUSE_TICKS;
            r_move_count  <= RST_MOVE_COUNT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_STEP_DIST: begin
                    r_cfg_steps <= w_prod[DIV5_SHIFT +: STEPS_W];
                    r_cfg_rev   <= w_dist[DIST_W-1];
                end
                CFG_PAUSE_TICKS: r_pause_ticks <= i_cfg.data;
                CFG_MOVE_COUNT:  r_move_count  <= i_cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_pop       = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
    assign w_dec       = r_moves_left - 16'd1;

    always_comb begin
        n_running    = r_running;
        n_phase      = r_phase;
        n_paused     = r_paused;
        n_cooldown   = r_cooldown;
        n_moves_left = r_moves_left;
        n_pause_rem  = r_pause_rem;
        n_out        = '0;
        w_key        = KEY_NONE;
        w_done       = 1'b0;

        if (i_item.command == CMD_START) begin
            if (!r_running) begin
                n_running = 1'b1;
                n_phase   = PH_START;
                n_paused  = 1'b0;
            end
        end else if (r_running) begin
            if (r_cooldown != '0) begin
                n_cooldown = r_cooldown - 8'd1;
            end else begin
                w_key = i_item.key;
            end

            if (r_phase == PH_EXIT) begin
                n_cooldown  = COOLDOWN_RELOAD;
                n_phase     = PH_START;
                n_paused    = 1'b0;
                n_running   = 1'b0;
                n_out.exited = 1'b1;
                w_done      = 1'b1;
            end else if (w_key == KEY_SELECT) begin
                n_paused           = !r_paused;
                n_out.display_code = r_paused ? DISP_RUNNING : DISP_PAUSED;
                n_cooldown         = COOLDOWN_RELOAD;
            end else if (w_key != KEY_NONE) begin
                n_out.display_code = DISP_ABORTED;
                n_phase            = PH_EXIT;
                n_paused           = 1'b0;
                n_cooldown         = COOLDOWN_RELOAD;
                w_done             = 1'b1;
            end

            if (!w_done && !n_paused) begin
                case (r_phase)
                    PH_START: begin
                        n_moves_left       = r_move_count;
                        n_out.display_code = DISP_RUNNING;
                        n_pause_rem        = r_pause_ticks;
                        n_phase            = PH_PAUSE;
                    end
                    PH_MOVE: begin
                        n_out.move_reverse = r_cfg_rev;
                        n_out.move_steps   = r_cfg_steps;
                        n_out.move_request = 1'b1;
                        n_phase            = PH_WAIT;
                    end
                    PH_WAIT: begin
                        if (!i_item.motion_busy) begin
                            n_moves_left = w_dec;
                            if (w_dec == '0) begin
                                n_phase            = PH_EXIT;
                                n_out.display_code = DISP_FINISHED;
                            end else begin
                                n_pause_rem        = r_pause_ticks;
                                n_phase            = PH_PAUSE;
                                n_out.display_code = DISP_RUNNING;
                            end
                        end
                    end
                    PH_PAUSE: begin
                        if (r_pause_rem != '0) begin
                            n_pause_rem = r_pause_rem - 32'd1;
                        end else begin
                            n_phase = PH_MOVE;
                        end
                    end
                    default: ;
                endcase
            end
        end

        n_out.steps_left = n_moves_left;
        n_out.active     = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_phase      <= PH_START;
            r_paused     <= 1'b0;
            r_cooldown   <= COOLDOWN_RELOAD;
            r_moves_left <= '0;
            r_pause_rem  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_running    <= n_running;
                r_phase      <= n_phase;
                r_paused     <= n_paused;
                r_cooldown   <= n_cooldown;
                r_moves_left <= n_moves_left;
                r_pause_rem  <= n_pause_rem;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    a_exit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.exited |-> !r_out.active)
        else $error("exit result still reports an active run");

    a_move_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.move_request |-> r_out.active && r_phase == PH_WAIT)
        else $error("move issued outside an active run");

    a_exit_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_EXIT |-> r_running)
        else $error("exit phase while idle");

    a_pause_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> !r_paused)
        else $error("paused flag set while idle");

endmodule
`default_nettype wire

[design/step_pause_move_sequencer_core.sv]
// Top level of the step/pause/move sequencer.
//
// Input stream (i_s_*): one transfer per tick or start command. tuser is the
// command (0 tick, 1 start a run if idle); tdata carries the keypad ADC
// sample and the motion-busy flag of that tick.
// Output stream (o_m_*): exactly one result transfer per input transfer, in
// order. tlast marks the tick on which the run ends.
// Config channel (i_cfg_*): register index and data, taken every cycle;
// 0 step distance in um (signed 22 bit), 1 pause ticks, 2 move count.
// Write it only while no input is outstanding.
// A result passes through a queue entry and the result register before it
// is offered. Throughput is one item per cycle while the receiver takes
// results; the back computes each state update combinationally.
// A two-entry queue sits between the classifier and the sequencer, and the
// result register is refilled in the cycle it is taken, so input keeps
// flowing while a result waits. When the receiver stalls, the result
// register holds, the queue takes transfers until both entries are used,
// and then o_s_tready drops.
// Reset (synchronous, active low) idles the sequencer, restores the config
// defaults (2000 um, 1000 ticks, 3 moves) and empties the queue.
`default_nettype none
module step_pause_move_sequencer_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [9:0] adc_sample, [10] motion_busy, [15:11] zero
    input  wire logic [spms_pkg::S_DATA_W-1:0]   i_s_tdata,
    // [0] command
    input  wire logic                            i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [0] move_request, [21:1] move_steps, [22] move_reverse,
    // [25:23] display_code, [41:26] steps_left, [42] active, [47:43] zero
    output logic [spms_pkg::M_DATA_W-1:0]        o_m_tdata,
    // exited
    output logic                                 o_m_tlast,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [spms_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [spms_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import spms_pkg::*;

    t_item   w_front_item;
    t_item   w_q_item;
    logic    w_q_full;
    logic    w_q_valid;
    logic    w_pop;
    t_cfg_wr w_cfg;
    t_result w_result;

    assign o_s_tready  = !w_q_full;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_cfg.valid = i_cfg_valid;
        w_cfg.index = i_cfg_index;
        w_cfg.data  = i_cfg_data;
    end

    spms_front u_front (
        .i_tuser (i_s_tuser),
        .i_tdata (i_s_tdata),
        .o_item  (w_front_item)
    );

    spms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    spms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_result    (w_result)
    );

    assign o_m_tlast = w_result.exited;
    assign o_m_tdata = {5'd0,
                        w_result.active,
                        w_result.steps_left,
                        w_result.display_code,
                        w_result.move_reverse,
                        w_result.move_steps,
                        w_result.move_request};

endmodule
`default_nettype wire
